FILE: src/zsbp_pkg.sv
// ----------------------------------------------------------------------------
// zsbp_pkg
// Types, widths and constants shared by the ZMODEM sender block pacing core.
// ----------------------------------------------------------------------------
package zsbp_pkg;

   localparam int POS_W       = 32;
   localparam int LEN_W       = 14;
   localparam int WINDOW_W    = 20;
   localparam int RXBUF_W     = 16;
   localparam int CSR_DATA_W  = 20;
   localparam int CSR_INDEX_W = 2;
   localparam int GOOD_W      = 5;

   localparam int RESYNC_RETRIES = 10;
   localparam int MAX_BLOCK      = 8192;
   localparam int RESYNC_W       = $clog2(RESYNC_RETRIES + 1);

   localparam logic [LEN_W-1:0]    MIN_BLOCK_LEN   = LEN_W'(32);
   localparam logic [LEN_W-1:0]    MAX_BLOCK_LEN   = LEN_W'(MAX_BLOCK);
   localparam logic [GOOD_W-1:0]   THRESH_INIT     = GOOD_W'(4);
   localparam logic [GOOD_W-1:0]   THRESH_MAX      = GOOD_W'(16);
   localparam logic [GOOD_W-1:0]   THRESH_SAT      = GOOD_W'(8);
   localparam logic [RESYNC_W-1:0] RESYNC_FULL     = RESYNC_W'(RESYNC_RETRIES);
   localparam logic [RESYNC_W-1:0] RESYNC_FIRST    = RESYNC_W'(RESYNC_RETRIES - 1);
   localparam logic [RESYNC_W-1:0] RESYNC_SHRINK   = RESYNC_W'(RESYNC_RETRIES - 2);

   // Register reset values
   localparam logic [LEN_W-1:0]    MAX_LEN_RESET   = LEN_W'(1024);
   localparam logic [LEN_W-1:0]    START_LEN_RESET = LEN_W'(512);
   localparam logic [WINDOW_W-1:0] WINDOW_RESET    = '0;
   localparam logic [RXBUF_W-1:0]  RXBUF_RESET     = '0;
   // Initial block length that the register reset values give
   localparam logic [LEN_W-1:0]    BLOCK_LEN_RESET = LEN_W'(512);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MAX_BLOCK_LEN   = 2'd0,
      REG_START_BLOCK_LEN = 2'd1,
      REG_WINDOW_SIZE     = 2'd2,
      REG_RX_BUFFER_LEN   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_START  = 2'd0,
      KIND_BLOCK  = 2'd1,
      KIND_RESEND = 2'd2,
      KIND_ACK    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_CONTINUE    = 3'd0,
      ST_WAIT_ACK    = 3'd1,
      ST_RESEND      = 3'd2,
      ST_ACK_TAKEN   = 3'd3,
      ST_ACK_IGNORED = 3'd4,
      ST_SYNC_ERROR  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      END_ZCRCG = 2'd0,
      END_ZCRCQ = 2'd1,
      END_ZCRCW = 2'd2,
      END_ZCRCE = 2'd3
   } end_type_type;

   typedef struct packed {
      kind_type             kind;
      logic [POS_W-1:0]     position;
      logic [LEN_W-1:0]     byte_count;
      logic                 end_of_file;
   } req_type;

   typedef struct packed {
      status_type           status;
      end_type_type         end_type;
      logic [LEN_W-1:0]     next_block_len;
      logic [POS_W-1:0]     send_position;
   } rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0]     ceil_len;
      logic [LEN_W-1:0]     init_len;
      logic [WINDOW_W-1:0]  window_size;
      logic [RXBUF_W-1:0]   rx_buf_len;
   } cfg_type;

endpackage

FILE: src/zsbp_req_if.sv
// ----------------------------------------------------------------------------
// zsbp_req_if
// Event channel into the pacing core: valid/ready with the event payload.
// ----------------------------------------------------------------------------
interface zsbp_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  kind;
   logic [zsbp_pkg::POS_W-1:0]  position;
   logic [zsbp_pkg::LEN_W-1:0]  byte_count;
   logic                        end_of_file;

   modport source (output valid, kind, position, byte_count, end_of_file, input ready);
   modport sink   (input valid, kind, position, byte_count, end_of_file, output ready);
endinterface

FILE: src/zsbp_rsp_if.sv
// ----------------------------------------------------------------------------
// zsbp_rsp_if
// Result channel out of the pacing core: valid/ready with the result payload.
// ----------------------------------------------------------------------------
interface zsbp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [2:0]                  status;
   logic [1:0]                  end_type;
   logic [zsbp_pkg::LEN_W-1:0]  next_block_len;
   logic [zsbp_pkg::POS_W-1:0]  send_position;

   modport source (output valid, status, end_type, next_block_len, send_position,
                   input ready);
   modport sink   (input valid, status, end_type, next_block_len, send_position,
                   output ready);
endinterface

FILE: src/zmodem_sender_block_pacing_core.sv
// A beat accepted on req_if passes the event register, then the result register, to rsp_if.
// Throughput: one beat per cycle; the event register and the result
// register each pass a beat on every cycle the result side takes one.
// The per-event state update is combinational between those registers.
// Reset (synchronous, active high) restores the configuration registers and
// pacing state to their defaults and empties both registers.
// ----------------------------------------------------------------------------
// zmodem_sender_block_pacing_core
// Data-phase pacing of a ZMODEM file sender: one result beat per event beat.
// ----------------------------------------------------------------------------
module zmodem_sender_block_pacing_core (
   input  logic                               clock,
   input  logic                               reset,
   zsbp_req_if.sink                           req_if,
   zsbp_rsp_if.source                         rsp_if,
   input  logic                               csr_we,
   input  logic [zsbp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [zsbp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   zsbp_pkg::cfg_type  cfg;
   zsbp_pkg::req_type  item_ff,  item_in;
   logic               item_valid_ff, item_valid_in;
   zsbp_pkg::rsp_type  result;
   zsbp_pkg::rsp_type  out_ff;
   logic               out_valid_ff, out_valid_in;
   logic               req_fire;
   logic               out_load;

   zsbp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   zsbp_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (out_load),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Advance the event register into the result register when it frees up
   assign out_load     = item_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !item_valid_ff || out_load;
   assign req_fire     = req_if.valid && req_if.ready;

   always_comb begin
      item_in.kind        = zsbp_pkg::kind_type'(req_if.kind);
      item_in.position    = req_if.position;
      item_in.byte_count  = req_if.byte_count;
      item_in.end_of_file = req_if.end_of_file;
      item_valid_in       = req_fire ? 1'b1 : (out_load ? 1'b0 : item_valid_ff);
      out_valid_in        = out_load ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) item_ff <= item_in;
      if (out_load) out_ff  <= result;
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.status         = out_ff.status;
   assign rsp_if.end_type       = out_ff.end_type;
   assign rsp_if.next_block_len = out_ff.next_block_len;
   assign rsp_if.send_position  = out_ff.send_position;

endmodule

FILE: src/zsbp_csr.sv
// ----------------------------------------------------------------------------
// zsbp_csr
// Configuration registers and the derived block length ceiling and start length.
// ----------------------------------------------------------------------------
module zsbp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [zsbp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [zsbp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output zsbp_pkg::cfg_type                   cfg
);

   logic [zsbp_pkg::LEN_W-1:0]    max_len_ff;
   logic [zsbp_pkg::LEN_W-1:0]    start_len_ff;
   logic [zsbp_pkg::WINDOW_W-1:0] window_ff;
   logic [zsbp_pkg::RXBUF_W-1:0]  rxbuf_ff;
   logic [zsbp_pkg::LEN_W-1:0]    ceil_len;
   logic [zsbp_pkg::LEN_W-1:0]    init_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= zsbp_pkg::MAX_LEN_RESET;
         start_len_ff <= zsbp_pkg::START_LEN_RESET;
         window_ff    <= zsbp_pkg::WINDOW_RESET;
         rxbuf_ff     <= zsbp_pkg::RXBUF_RESET;
      end else if (csr_we) begin
         unique case (zsbp_pkg::csr_index_type'(csr_index))
            zsbp_pkg::REG_MAX_BLOCK_LEN:   max_len_ff   <= csr_wdata[zsbp_pkg::LEN_W-1:0];
            zsbp_pkg::REG_START_BLOCK_LEN: start_len_ff <= csr_wdata[zsbp_pkg::LEN_W-1:0];
            zsbp_pkg::REG_WINDOW_SIZE:     window_ff    <= csr_wdata[zsbp_pkg::WINDOW_W-1:0];
            zsbp_pkg::REG_RX_BUFFER_LEN:   rxbuf_ff     <= csr_wdata[zsbp_pkg::RXBUF_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the ceiling to the legal range, then to the receiver buffer
   always_comb begin
      ceil_len = max_len_ff;
      if (ceil_len < zsbp_pkg::MIN_BLOCK_LEN) ceil_len = zsbp_pkg::MIN_BLOCK_LEN;
      if (ceil_len > zsbp_pkg::MAX_BLOCK_LEN) ceil_len = zsbp_pkg::MAX_BLOCK_LEN;
      if (rxbuf_ff != '0 && {2'b00, ceil_len} > rxbuf_ff) begin
         ceil_len = rxbuf_ff[zsbp_pkg::LEN_W-1:0];
      end
      if (ceil_len < zsbp_pkg::MIN_BLOCK_LEN) ceil_len = zsbp_pkg::MIN_BLOCK_LEN;

      init_len = start_len_ff;
      if (init_len < zsbp_pkg::MIN_BLOCK_LEN) init_len = zsbp_pkg::MIN_BLOCK_LEN;
      if (init_len > ceil_len) init_len = ceil_len;
   end

   assign cfg.ceil_len    = ceil_len;
   assign cfg.init_len    = init_len;
   assign cfg.window_size = window_ff;
   assign cfg.rx_buf_len  = rxbuf_ff;

endmodule

FILE: src/zsbp_engine.sv
// ----------------------------------------------------------------------------
// zsbp_engine
// Sender pacing state and the per-event update: positions, block length,
// good-block counting, resync retries and receiver buffer credit.
// ----------------------------------------------------------------------------
module zsbp_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  zsbp_pkg::req_type   item,
   input  zsbp_pkg::cfg_type   cfg,
   output zsbp_pkg::rsp_type   result
);

   logic [zsbp_pkg::POS_W-1:0]    tx_pos_ff,   tx_pos_in;
   logic [zsbp_pkg::POS_W-1:0]    rx_pos_ff,   rx_pos_in;
   logic [zsbp_pkg::LEN_W-1:0]    blk_len_ff,  blk_len_in;
   logic [zsbp_pkg::GOOD_W-1:0]   good_ff,     good_in;
   logic [zsbp_pkg::GOOD_W-1:0]   thresh_ff,   thresh_in;
   logic [zsbp_pkg::POS_W-1:0]    rs_pos_ff,   rs_pos_in;
   logic                          rs_valid_ff, rs_valid_in;
   logic [zsbp_pkg::RESYNC_W-1:0] rs_left_ff,  rs_left_in;
   logic [zsbp_pkg::RXBUF_W-1:0]  credit_ff,   credit_in;

   zsbp_pkg::status_type          status;
   zsbp_pkg::end_type_type        etype;
   logic [zsbp_pkg::GOOD_W-1:0]   good_inc;
   logic [zsbp_pkg::LEN_W:0]      dbl_len;
   logic [zsbp_pkg::LEN_W-1:0]    qtr_len;
   logic [zsbp_pkg::POS_W:0]      win_limit;
   logic                          win_full;
   logic                          repeat_pos;
   logic                          ack_ok;

   always_comb begin
      tx_pos_in   = tx_pos_ff;
      rx_pos_in   = rx_pos_ff;
      blk_len_in  = blk_len_ff;
      good_in     = good_ff;
      thresh_in   = thresh_ff;
      rs_pos_in   = rs_pos_ff;
      rs_valid_in = rs_valid_ff;
      rs_left_in  = rs_left_ff;
      credit_in   = credit_ff;
      status      = zsbp_pkg::ST_CONTINUE;
      etype       = zsbp_pkg::END_ZCRCG;
      good_inc    = good_ff + 1'b1;
      dbl_len     = {blk_len_ff, 1'b0};
      qtr_len     = blk_len_ff >> 2;
      win_limit   = '0;
      win_full    = 1'b0;
      repeat_pos  = rs_valid_ff && (item.position == rs_pos_ff);
      ack_ok      = 1'b0;

      case (item.kind)
         zsbp_pkg::KIND_START: begin
            tx_pos_in   = item.position;
            rx_pos_in   = item.position;
            blk_len_in  = cfg.init_len;
            good_in     = zsbp_pkg::GOOD_W'(1);
            thresh_in   = zsbp_pkg::THRESH_INIT;
            rs_valid_in = 1'b0;
            rs_pos_in   = '0;
            rs_left_in  = zsbp_pkg::RESYNC_FULL;
            credit_in   = cfg.rx_buf_len;
         end
         zsbp_pkg::KIND_BLOCK: begin
            if (item.end_of_file) begin
               etype = zsbp_pkg::END_ZCRCE;
            end else if (cfg.rx_buf_len != '0 && {2'b00, item.byte_count} >= credit_ff) begin
               credit_in = '0;
               etype     = zsbp_pkg::END_ZCRCW;
            end else begin
               if (cfg.rx_buf_len != '0) credit_in = credit_ff - {2'b00, item.byte_count};
               etype = (cfg.window_size != '0) ? zsbp_pkg::END_ZCRCQ : zsbp_pkg::END_ZCRCG;
            end
            tx_pos_in = tx_pos_ff + {{(zsbp_pkg::POS_W - zsbp_pkg::LEN_W){1'b0}},
                                     item.byte_count};
            // Grow the block after a run of good blocks, never past the ceiling
            if (blk_len_ff < cfg.ceil_len) begin
               good_in = good_inc;
               if (good_inc > thresh_ff) begin
                  blk_len_in = (dbl_len < {1'b0, cfg.ceil_len}) ?
                               dbl_len[zsbp_pkg::LEN_W-1:0] : cfg.ceil_len;
                  good_in    = zsbp_pkg::GOOD_W'(1);
               end
            end
            win_limit = {1'b0, rx_pos_ff} +
                        {{(zsbp_pkg::POS_W + 1 - zsbp_pkg::WINDOW_W){1'b0}}, cfg.window_size};
            win_full  = (cfg.window_size != '0) && ({1'b0, tx_pos_in} >= win_limit);
            status    = (etype == zsbp_pkg::END_ZCRCW || etype == zsbp_pkg::END_ZCRCE ||
                         win_full) ? zsbp_pkg::ST_WAIT_ACK : zsbp_pkg::ST_CONTINUE;
         end
         zsbp_pkg::KIND_RESEND: begin
            rx_pos_in = item.position;
            if (repeat_pos && rs_left_ff == '0) begin
               status = zsbp_pkg::ST_SYNC_ERROR;
            end else begin
               status      = zsbp_pkg::ST_RESEND;
               rs_left_in  = repeat_pos ? rs_left_ff - 1'b1 : zsbp_pkg::RESYNC_FIRST;
               rs_pos_in   = item.position;
               rs_valid_in = 1'b1;
               tx_pos_in   = item.position;
               // Repeated trouble: quarter the block, demand more good blocks
               if (rs_left_in < zsbp_pkg::RESYNC_SHRINK) begin
                  blk_len_in = (qtr_len > zsbp_pkg::MIN_BLOCK_LEN) ?
                               qtr_len : zsbp_pkg::MIN_BLOCK_LEN;
                  thresh_in  = (thresh_ff >= zsbp_pkg::THRESH_SAT) ?
                               zsbp_pkg::THRESH_MAX : {thresh_ff[zsbp_pkg::GOOD_W-2:0], 1'b0};
               end
               good_in   = '0;
               credit_in = cfg.rx_buf_len;
            end
         end
         zsbp_pkg::KIND_ACK: begin
            rx_pos_in = item.position;
            win_limit = {1'b0, item.position} +
                        {{(zsbp_pkg::POS_W + 1 - zsbp_pkg::WINDOW_W){1'b0}}, cfg.window_size};
            ack_ok    = (cfg.window_size == '0) ? (tx_pos_ff == item.position) :
                        ({1'b0, tx_pos_ff} < win_limit);
            if (ack_ok) begin
               status    = zsbp_pkg::ST_ACK_TAKEN;
               credit_in = cfg.rx_buf_len;
            end else begin
               status = zsbp_pkg::ST_ACK_IGNORED;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_pos_ff   <= '0;
         rx_pos_ff   <= '0;
         blk_len_ff  <= zsbp_pkg::BLOCK_LEN_RESET;
         good_ff     <= zsbp_pkg::GOOD_W'(1);
         thresh_ff   <= zsbp_pkg::THRESH_INIT;
         rs_pos_ff   <= '0;
         rs_valid_ff <= 1'b0;
         rs_left_ff  <= zsbp_pkg::RESYNC_FULL;
         credit_ff   <= zsbp_pkg::RXBUF_RESET;
      end else if (fire) begin
         tx_pos_ff   <= tx_pos_in;
         rx_pos_ff   <= rx_pos_in;
         blk_len_ff  <= blk_len_in;
         good_ff     <= good_in;
         thresh_ff   <= thresh_in;
         rs_pos_ff   <= rs_pos_in;
         rs_valid_ff <= rs_valid_in;
         rs_left_ff  <= rs_left_in;
         credit_ff   <= credit_in;
      end
   end

   assign result.status         = status;
   assign result.end_type       = etype;
   assign result.next_block_len = blk_len_in;
   assign result.send_position  = tx_pos_in;

endmodule

FILE: bench/zmodem_sender_block_pacing_checker.sv
// ----------------------------------------------------------------------------
// zmodem_sender_block_pacing_checker
// Watches the event, result and register ports of the pacing core, keeps its
// own copy of the pacing state, predicts each result beat and compares it
// field by field against what the core returns.
// ----------------------------------------------------------------------------
module zmodem_sender_block_pacing_checker
   import zsbp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   zsbp_req_if                    req_mon,
   zsbp_rsp_if                    rsp_mon,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // register copies
   logic [LEN_W-1:0]    max_len_reg;
   logic [LEN_W-1:0]    start_len_reg;
   logic [WINDOW_W-1:0] window_reg;
   logic [RXBUF_W-1:0]  rxbuf_reg;

   // pacing state
   logic [POS_W-1:0]    tx_pos;
   logic [POS_W-1:0]    rx_pos;
   logic [POS_W-1:0]    resync_pos;
   logic                resync_seen;
   int                  block_len;
   int                  good_run;
   int                  good_limit;
   int                  resync_left;
   int                  credit;

   rsp_type             expected_rsp_q[$];
   req_type             ev;
   rsp_type             want;

   function automatic int ceiling_len();
      int m;
      m = max_len_reg;
      if (m < MIN_BLOCK_LEN) m = MIN_BLOCK_LEN;
      if (m > MAX_BLOCK) m = MAX_BLOCK;
      if (rxbuf_reg != 0 && m > rxbuf_reg) m = rxbuf_reg;
      if (m < MIN_BLOCK_LEN) m = MIN_BLOCK_LEN;
      return m;
   endfunction

   function automatic int initial_len();
      int s;
      int m;
      s = start_len_reg;
      m = ceiling_len();
      if (s < MIN_BLOCK_LEN) s = MIN_BLOCK_LEN;
      if (s > m) s = m;
      return s;
   endfunction

   function automatic logic window_full();
      logic [63:0] sent;
      logic [63:0] limit;
      sent  = tx_pos;
      limit = 64'(rx_pos) + 64'(window_reg);
      return window_reg != 0 && sent >= limit;
   endfunction

   function automatic void start_session(input logic [POS_W-1:0] position);
      tx_pos      = position;
      rx_pos      = position;
      block_len   = initial_len();
      good_run    = 1;
      good_limit  = THRESH_INIT;
      resync_seen = 1'b0;
      resync_pos  = '0;
      resync_left = RESYNC_RETRIES;
      credit      = rxbuf_reg;
   endfunction

   // Advance the pacing state by one event and return the result it causes.
   function automatic rsp_type pace_event(input req_type e);
      rsp_type     r;
      int          ceil_now;
      int          cnt;
      logic [63:0] acked;
      logic        ok;
      r.status   = ST_CONTINUE;
      r.end_type = END_ZCRCG;
      ceil_now   = ceiling_len();
      cnt        = e.byte_count;
      case (e.kind)
         KIND_START: begin
            start_session(e.position);
         end
         KIND_BLOCK: begin
            if (e.end_of_file) begin
               r.end_type = END_ZCRCE;
            end else if (rxbuf_reg != 0 && cnt >= credit) begin
               credit     = 0;
               r.end_type = END_ZCRCW;
            end else begin
               if (rxbuf_reg != 0) credit -= cnt;
               r.end_type = (window_reg != 0) ? END_ZCRCQ : END_ZCRCG;
            end
            tx_pos += POS_W'(cnt);
            // grow only below the ceiling; a length above it stays put
            if (block_len < ceil_now) begin
               good_run++;
               if (good_run > good_limit) begin
                  block_len = (2 * block_len < ceil_now) ? 2 * block_len : ceil_now;
                  good_run  = 1;
               end
            end
            r.status = (r.end_type == END_ZCRCW || r.end_type == END_ZCRCE || window_full())
                       ? ST_WAIT_ACK : ST_CONTINUE;
         end
         KIND_RESEND: begin
            rx_pos = e.position;
            if (resync_seen && e.position == resync_pos) begin
               if (resync_left == 0) begin
                  r.status = ST_SYNC_ERROR;
               end else begin
                  resync_left--;
                  r.status = ST_RESEND;
               end
            end else begin
               resync_left = RESYNC_RETRIES - 1;
               r.status    = ST_RESEND;
            end
            if (r.status == ST_RESEND) begin
               resync_pos  = e.position;
               resync_seen = 1'b1;
               tx_pos      = e.position;
               // repeated trouble: quarter the length, demand more good blocks
               if (resync_left < RESYNC_RETRIES - 2) begin
                  block_len  = (block_len / 4 > MIN_BLOCK_LEN) ? block_len / 4 : MIN_BLOCK_LEN;
                  good_limit = (2 * good_limit > THRESH_MAX) ? THRESH_MAX : 2 * good_limit;
               end
               good_run = 0;
               credit   = rxbuf_reg;
            end
         end
         default: begin
            rx_pos = e.position;
            acked  = 64'(e.position) + 64'(window_reg);
            if (window_reg == 0) ok = (tx_pos == e.position);
            else                 ok = (64'(tx_pos) < acked);
            if (ok) begin
               r.status = ST_ACK_TAKEN;
               credit   = rxbuf_reg;
            end else begin
               r.status = ST_ACK_IGNORED;
            end
         end
      endcase
      r.next_block_len = LEN_W'(block_len);
      r.send_position  = tx_pos;
      return r;
   endfunction

   task automatic report_error(input string msg);
      $display("%0t ERROR %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] exp_val);
      if (got !== exp_val)
         report_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, exp_val));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         max_len_reg   = MAX_LEN_RESET;
         start_len_reg = START_LEN_RESET;
         window_reg    = WINDOW_RESET;
         rxbuf_reg     = RXBUF_RESET;
         start_session('0);
         expected_rsp_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_MAX_BLOCK_LEN:   max_len_reg   = csr_wdata[LEN_W-1:0];
               REG_START_BLOCK_LEN: start_len_reg = csr_wdata[LEN_W-1:0];
               REG_WINDOW_SIZE:     window_reg    = csr_wdata[WINDOW_W-1:0];
               default:             rxbuf_reg     = csr_wdata[RXBUF_W-1:0];
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_rsp_q.size() == 0) begin
               report_error("result beat with no event outstanding");
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("status", 32'(rsp_mon.status), 32'(want.status));
               check_field("end_type", 32'(rsp_mon.end_type), 32'(want.end_type));
               check_field("next_block_len", 32'(rsp_mon.next_block_len),
                           32'(want.next_block_len));
               check_field("send_position", rsp_mon.send_position, want.send_position);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            ev.kind        = kind_type'(req_mon.kind);
            ev.position    = req_mon.position;
            ev.byte_count  = req_mon.byte_count;
            ev.end_of_file = req_mon.end_of_file;
            expected_rsp_q.push_back(pace_event(ev));
         end
      end
      pending = expected_rsp_q.size();
   end

endmodule

FILE: bench/zmodem_sender_block_pacing_core_tb.sv
// ----------------------------------------------------------------------------
// zmodem_sender_block_pacing_core_tb
// Drives protocol events into the pacing core under a series of register
// settings: a directed opening, then sessions of mostly well-formed traffic
// (blocks, acknowledges, repeated resend requests) mixed with random events.
// Both channels idle at random; a checker beside the core judges every beat.
// ----------------------------------------------------------------------------
module zmodem_sender_block_pacing_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import zsbp_pkg::*;

   localparam int SESSIONS      = 12;
   localparam int SESSION_BEATS = 110;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   int                     fail_count;
   int                     pending;
   logic                   no_idle = 1'b0;
   logic [POS_W-1:0]       sent_pos = '0;

   zsbp_req_if req_if ();
   zsbp_rsp_if rsp_if ();

   zmodem_sender_block_pacing_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   zmodem_sender_block_pacing_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("zmodem_sender_block_pacing_core_tb failed");
      $finish;
   end

   // mostly short gaps, a few long ones, none while no_idle is set
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_len();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return MIN_BLOCK_LEN;
         2:       return MAX_BLOCK;
         3:       return 16383;
         4:       return $urandom_range(0, 31);
         default: return $urandom_range(32, MAX_BLOCK);
      endcase
   endfunction

   function automatic int pick_window();
      case ($urandom_range(0, 9))
         0, 1, 2: return 0;
         3:       return 1;
         4:       return 20'hFFFFF;
         5:       return $urandom_range(0, 20'hFFFFF);
         default: return $urandom_range(64, 20000);
      endcase
   endfunction

   function automatic int pick_rxbuf();
      case ($urandom_range(0, 9))
         0, 1, 2: return 0;
         3:       return 1;
         4:       return 16'hFFFF;
         5:       return $urandom_range(0, 16'hFFFF);
         default: return $urandom_range(32, 4000);
      endcase
   endfunction

   function automatic int pick_count();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return MAX_BLOCK;
         2, 3:    return $urandom_range(0, MAX_BLOCK);
         default: return $urandom_range(1, 1024);
      endcase
   endfunction

   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      forever begin
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   task automatic send_event(input kind_type kind, input logic [POS_W-1:0] position,
                             input int count, input logic eof);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.kind        <= kind;
      req_if.position    <= position;
      req_if.byte_count  <= LEN_W'(count);
      req_if.end_of_file <= eof;
      do @(posedge clock); while (!req_if.ready);
      case (kind)
         KIND_BLOCK:               sent_pos += POS_W'(count);
         KIND_START, KIND_RESEND:  sent_pos = position;
         default:                  ;
      endcase
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // lengths sometimes carry junk above bit 13, which the core must drop
   task automatic write_config(input int max_len, input int start_len,
                               input int window, input int rxbuf);
      logic [CSR_DATA_W-1:0] junk;
      junk = ($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom) : '0;
      write_reg(REG_MAX_BLOCK_LEN, {junk[CSR_DATA_W-1:LEN_W], LEN_W'(max_len)});
      write_reg(REG_START_BLOCK_LEN, {junk[CSR_DATA_W-1:LEN_W], LEN_W'(start_len)});
      write_reg(REG_WINDOW_SIZE, CSR_DATA_W'(window));
      write_reg(REG_RX_BUFFER_LEN, CSR_DATA_W'(rxbuf));
      csr_we <= 1'b0;
   endtask

   task automatic run_session(input int beats);
      int               done;
      int               repeats;
      logic [POS_W-1:0] where;
      done = 0;
      while (done < beats) begin
         case ($urandom_range(0, 99)) inside
            [0:59]: begin
               send_event(KIND_BLOCK, POS_W'($urandom), pick_count(),
                          $urandom_range(0, 19) == 0);
               done++;
            end
            [60:71]: begin
               case ($urandom_range(0, 3))
                  0, 1:    where = sent_pos;
                  2:       where = sent_pos - POS_W'($urandom_range(0, 4096));
                  default: where = POS_W'($urandom);
               endcase
               send_event(KIND_ACK, where, $urandom_range(0, MAX_BLOCK), $urandom_range(0, 1));
               done++;
            end
            [72:81]: begin
               // a receiver stuck on one position repeats the same request
               where   = sent_pos - POS_W'($urandom_range(0, MAX_BLOCK));
               repeats = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 13)
                                                     : $urandom_range(1, 3);
               repeat (repeats) begin
                  send_event(KIND_RESEND, where, $urandom_range(0, MAX_BLOCK),
                             $urandom_range(0, 1));
                  done++;
               end
            end
            [82:84]: begin
               send_event(KIND_START, POS_W'($urandom), 0, 1'b0);
               done++;
            end
            default: begin
               send_event(kind_type'($urandom_range(0, 3)), POS_W'($urandom),
                          $urandom_range(0, MAX_BLOCK), $urandom_range(0, 1));
               done++;
            end
         endcase
      end
   endtask

   initial begin
      req_if.valid       = 1'b0;
      req_if.kind        = KIND_START;
      req_if.position    = '0;
      req_if.byte_count  = '0;
      req_if.end_of_file = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed opening on the reset settings
      send_event(KIND_START, 32'hFFFF_FF00, 0, 1'b0);
      send_event(KIND_BLOCK, 32'h0, MAX_BLOCK, 1'b0);        // position wraps
      send_event(KIND_BLOCK, 32'hFFFF_FFFF, 0, 1'b1);        // file end
      send_event(KIND_ACK, sent_pos, 0, 1'b0);               // taken
      send_event(KIND_ACK, 32'hFFFF_FFFF, MAX_BLOCK, 1'b1);  // ignored
      send_event(KIND_BLOCK, 32'h0, 1, 1'b0);
      // same resend position until the retries run out
      repeat (RESYNC_RETRIES + 1) send_event(KIND_RESEND, 32'h0000_1234, 0, 1'b0);
      send_event(KIND_START, 32'h0, 0, 1'b0);
      repeat (4) send_event(KIND_BLOCK, 32'h0, 512, 1'b0);   // length doubles
      wait_idle();

      for (int s = 0; s < SESSIONS; s++) begin
         no_idle <= (s % 4 == 3);
         case (s)
            0:       write_config(16383, 0, 20'hFFFFF, 16'hFFFF);
            1:       write_config(0, 16383, 1, 1);
            2:       write_config(MAX_BLOCK, MIN_BLOCK_LEN, 0, 0);
            default: write_config(pick_len(), pick_len(), pick_window(), pick_rxbuf());
         endcase
         // keep the old session now and then, so a lowered ceiling meets a long block
         if (s < 3 || $urandom_range(0, 3) != 0) begin
            send_event(KIND_START,
                       ($urandom_range(0, 3) == 0) ? 32'hFFFF_0000 : POS_W'($urandom),
                       0, 1'b0);
         end
         run_session(SESSION_BEATS);
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("zmodem_sender_block_pacing_core_tb passed");
      end else begin
         $display("zmodem_sender_block_pacing_core_tb failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/zsbp_pkg.sv
src/zsbp_req_if.sv
src/zsbp_rsp_if.sv
src/zsbp_csr.sv
src/zsbp_engine.sv
src/zmodem_sender_block_pacing_core.sv
bench/zmodem_sender_block_pacing_checker.sv
bench/zmodem_sender_block_pacing_core_tb.sv
